@@ src/gpcc_pkg.sv @@
// ---------------------------------------------------------------------------
// gpcc_pkg - shared types and constants of the green pixel counter
// Field widths, register reset values, channel expansion tables and the
// command/status bundles that join the controller and the datapath.
// ---------------------------------------------------------------------------
package gpcc_pkg;

	localparam int GRID_W_DEF = 80;
	localparam int GRID_H_DEF = 60;

	localparam int PIX_W       = 16;
	localparam int COORD_W     = 12;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 19;
	localparam int MEAN_W      = 7;
	localparam int FRAME_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

	localparam logic [11:0] RST_FRAME_W   = 12'd320;
	localparam logic [11:0] RST_FRAME_H   = 12'd240;
	localparam logic [7:0]  RST_MIN_GREEN = 8'd75;
	localparam logic [7:0]  RST_GREENNESS = 8'd30;

	typedef logic [31:0][7:0] exp5_tab_t;
	typedef logic [63:0][7:0] exp6_tab_t;

	function automatic exp5_tab_t build_exp5();
		exp5_tab_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255) / 31);
		end
		return t;
	endfunction

	function automatic exp6_tab_t build_exp6();
		exp6_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255) / 63);
		end
		return t;
	endfunction

	localparam exp5_tab_t EXP5_TAB = build_exp5();
	localparam exp6_tab_t EXP6_TAB = build_exp6();

	typedef struct packed {
		logic load_px;
		logic scan_step;
		logic mul;
		logic acc;
		logic div_init;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic green;
		logic px_last;
		logic last_q;
		logic scan_done;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ src/gpcc_ctrl.sv @@
// ---------------------------------------------------------------------------
// gpcc_ctrl - sequencer of the green pixel counter
// Steps each accepted green pixel through grid scan, multiply, accumulate and,
// at the end of a frame, the serial divide and the result transfer.
// ---------------------------------------------------------------------------
module gpcc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  gpcc_pkg::sts_t  sts,
	output gpcc_pkg::cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_ACC   = 7'b0001000,
		ST_DINIT = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && sts.active) begin
					cmd.load_px = 1'b1;
					if (sts.green) begin
						state_d = ST_SCAN;
					end else if (sts.px_last) begin
						state_d = ST_DINIT;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last_q ? ST_DINIT : ST_IDLE;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/gpcc_dp.sv @@
// ---------------------------------------------------------------------------
// gpcc_dp - datapath of the green pixel counter
// Register file, color test, grid point scan, saturating accumulators,
// restoring divider for the mean column and the result register.
// ---------------------------------------------------------------------------
module gpcc_dp #(
	parameter int GRID_W = gpcc_pkg::GRID_W_DEF,
	parameter int GRID_H = gpcc_pkg::GRID_H_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [gpcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gpcc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [gpcc_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tlast,
	input  gpcc_pkg::cmd_t                      cmd,
	output gpcc_pkg::sts_t                      sts,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gpcc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int CNT_W  = gpcc_pkg::CNT_W;
	localparam int SUM_W  = gpcc_pkg::SUM_W;
	localparam int MEAN_W = gpcc_pkg::MEAN_W;
	localparam int GMAX   = (GRID_W > GRID_H) ? GRID_W : GRID_H;
	localparam int GC_W   = $clog2(GMAX);
	localparam int GX_W   = $clog2(GRID_W);
	localparam int NC_W   = $clog2(GRID_W + 1);
	localparam int NR_W   = $clog2(GRID_H + 1);
	localparam int XS_W   = $clog2(GRID_W * (GRID_W - 1) / 2 + 1);
	localparam int B_W    = $clog2((1 << gpcc_pkg::COORD_W) * GMAX + 1);
	localparam int PC_W   = NR_W + NC_W;
	localparam int PS_W   = NR_W + XS_W;
	localparam int CA_W   = ((PC_W > CNT_W) ? PC_W : CNT_W) + 1;
	localparam int SA_W   = ((PS_W > SUM_W) ? PS_W : SUM_W) + 1;
	localparam int CAP    = (GRID_W - 1 < (1 << MEAN_W) - 1) ? GRID_W - 1 : (1 << MEAN_W) - 1;
	localparam int DC_W   = $clog2(SUM_W);

	typedef enum logic [gpcc_pkg::CFG_IDX_W-1:0] {
		CFG_ENABLED   = 3'd0,
		CFG_FRAME_W   = 3'd1,
		CFG_FRAME_H   = 3'd2,
		CFG_MIN_GREEN = 3'd3,
		CFG_GREENNESS = 3'd4,
		CFG_MIRROR_X  = 3'd5
	} cfg_idx_t;

	// register file
	logic        enabled_q;
	logic [11:0] fw_q;
	logic [11:0] fh_q;
	logic [7:0]  ming_q;
	logic [7:0]  gmin_q;
	logic        mirror_q;
	logic        disable_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			fw_q      <= gpcc_pkg::RST_FRAME_W;
			fh_q      <= gpcc_pkg::RST_FRAME_H;
			ming_q    <= gpcc_pkg::RST_MIN_GREEN;
			gmin_q    <= gpcc_pkg::RST_GREENNESS;
			mirror_q  <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLED:   enabled_q <= cfg_data[0];
				CFG_FRAME_W:   fw_q      <= cfg_data[11:0];
				CFG_FRAME_H:   fh_q      <= cfg_data[11:0];
				CFG_MIN_GREEN: ming_q    <= cfg_data[7:0];
				CFG_GREENNESS: gmin_q    <= cfg_data[7:0];
				CFG_MIRROR_X:  mirror_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign disable_wr = cfg_valid && (cfg_idx_t'(cfg_index) == CFG_ENABLED) && !cfg_data[0];

	// color test
	logic [7:0] r8, g8, b8, half_rb;
	logic [8:0] rb_sum;
	logic [11:0] in_col, in_row;

	assign r8      = gpcc_pkg::EXP5_TAB[s_tdata[15:11]];
	assign g8      = gpcc_pkg::EXP6_TAB[s_tdata[10:5]];
	assign b8      = gpcc_pkg::EXP5_TAB[s_tdata[4:0]];
	assign rb_sum  = {1'b0, r8} + {1'b0, b8};
	assign half_rb = rb_sum[8:1];
	assign in_col  = s_tdata[27:16];
	assign in_row  = s_tdata[39:28];

	// pixel bounds on the grid: hit when lo <= g*size < hi
	logic [B_W-1:0] lo_c_q, hi_c_q, lo_r_q, hi_r_q;
	logic           last_q;

	always_ff @(posedge clk) begin
		if (cmd.load_px) begin
			lo_c_q <= B_W'(in_col) * B_W'(GRID_W);
			hi_c_q <= (B_W'(in_col) + B_W'(1)) * B_W'(GRID_W);
			lo_r_q <= B_W'(in_row) * B_W'(GRID_H);
			hi_r_q <= (B_W'(in_row) + B_W'(1)) * B_W'(GRID_H);
			last_q <= s_tlast;
		end
	end

	// grid scan
	logic [GC_W-1:0] g_q;
	logic [B_W-1:0]  accc_q, accr_q;
	logic [NC_W-1:0] ncol_q;
	logic [NR_W-1:0] nrow_q;
	logic [XS_W-1:0] xsum_q;
	logic [GX_W-1:0] gx, lcol;
	logic            hit_c, hit_r;

	assign gx    = g_q[GX_W-1:0];
	assign lcol  = mirror_q ? (GX_W'(GRID_W - 1) - gx) : gx;
	assign hit_c = ({1'b0, g_q} < (GC_W + 1)'(GRID_W)) && (accc_q >= lo_c_q) && (accc_q < hi_c_q);
	assign hit_r = ({1'b0, g_q} < (GC_W + 1)'(GRID_H)) && (accr_q >= lo_r_q) && (accr_q < hi_r_q);

	always_ff @(posedge clk) begin
		if (cmd.load_px) begin
			g_q    <= '0;
			accc_q <= '0;
			accr_q <= '0;
			ncol_q <= '0;
			nrow_q <= '0;
			xsum_q <= '0;
		end else if (cmd.scan_step) begin
			g_q    <= g_q + GC_W'(1);
			accc_q <= accc_q + B_W'(fw_q);
			accr_q <= accr_q + B_W'(fh_q);
			if (hit_c) begin
				ncol_q <= ncol_q + NC_W'(1);
				xsum_q <= xsum_q + XS_W'(lcol);
			end
			if (hit_r) begin
				nrow_q <= nrow_q + NR_W'(1);
			end
		end
	end

	// products
	logic [PC_W-1:0] prodc_q;
	logic [PS_W-1:0] prods_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prodc_q <= PC_W'(nrow_q) * PC_W'(ncol_q);
			prods_q <= PS_W'(nrow_q) * PS_W'(xsum_q);
		end
	end

	// saturating accumulators
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [CA_W-1:0]  cnt_add;
	logic [SA_W-1:0]  sum_add;

	assign cnt_add = CA_W'(cnt_q) + CA_W'(prodc_q);
	assign sum_add = SA_W'(sum_q) + SA_W'(prods_q);

	// divider and result
	logic [CNT_W:0]     rem_q, rem_sh;
	logic [SUM_W-1:0]   quo_q;
	logic [DC_W-1:0]    dcnt_q;
	logic               rem_ge;
	logic [MEAN_W-1:0]  mean;
	logic               out_valid_q;
	logic               out_found_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic [MEAN_W-1:0]  out_mean_q;
	logic [gpcc_pkg::FRAME_W-1:0] frame_q;

	assign rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign rem_ge = rem_sh >= {1'b0, cnt_q};
	assign mean   = (cnt_q == '0) ? '0 :
	                (quo_q > SUM_W'(CAP)) ? MEAN_W'(CAP) : quo_q[MEAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (disable_wr || cmd.emit) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.acc) begin
			cnt_q <= (cnt_add > CA_W'(gpcc_pkg::COUNT_MAX)) ? gpcc_pkg::COUNT_MAX
			                                                : cnt_add[CNT_W-1:0];
			sum_q <= (sum_add > SA_W'(gpcc_pkg::SUM_MAX)) ? gpcc_pkg::SUM_MAX
			                                              : sum_add[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= sum_q;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
			quo_q  <= {quo_q[SUM_W-2:0], rem_ge};
			dcnt_q <= dcnt_q + DC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			frame_q     <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				frame_q     <= frame_q + gpcc_pkg::FRAME_W'(1);
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_found_q <= (cnt_q != '0);
			out_cnt_q   <= cnt_q;
			out_mean_q  <= mean;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, frame_q, out_mean_q, out_cnt_q, out_found_q};

	assign sts.active    = enabled_q && (fw_q != '0) && (fh_q != '0);
	assign sts.green     = (g8 > ming_q) && ({1'b0, g8} > ({1'b0, half_rb} + {1'b0, gmin_q}));
	assign sts.px_last   = s_tlast;
	assign sts.last_q    = last_q;
	assign sts.scan_done = (g_q == GC_W'(GMAX - 1));
	assign sts.div_done  = (dcnt_q == DC_W'(SUM_W - 1));
	assign sts.out_free  = !out_valid_q || m_tready;

	a_emit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result register not loaded after emit");

	a_frame_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (frame_q == $past(frame_q) + gpcc_pkg::FRAME_W'(1)))
		else $error("frame number did not advance by one");

	a_found_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_found_q == (out_cnt_q != '0)))
		else $error("found flag disagrees with count");

	a_mean_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mean_q <= MEAN_W'(CAP)))
		else $error("mean column beyond grid");

	a_empty_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_mean_q == '0))
		else $error("mean column nonzero with no samples");

endmodule

@@ src/green_pixel_count_centroid.sv @@
// ---------------------------------------------------------------------------
// green_pixel_count_centroid - green sample counter and mean column
// Counts green RGB565 samples on a subsampling grid and reports, per frame,
// the count, the mean grid column and a running frame number.
//
//  channel  | direction | transfer when          | content
//  s_axis   | in        | tvalid & tready        | tdata pixel/col/row, tlast end of frame
//  m_axis   | out       | tvalid & tready        | tdata found/count/mean/frame
//  cfg      | in        | cfg_valid & cfg_ready  | cfg_index register, cfg_data value
//
// A non-green pixel is taken in the idle state. A green pixel then runs the grid
// scan that tests one grid point per cycle, then multiply and add; the last
// pixel of a frame then runs the bit-serial 19-bit divide and the result load.
// s_axis waits while a pixel is processed and while a new result waits for m_axis.
// Reset is asynchronous; it clears sequencer, registers, totals, frame and tvalid.
// ---------------------------------------------------------------------------
module green_pixel_count_centroid #(
	parameter int GRID_W = gpcc_pkg::GRID_W_DEF,
	parameter int GRID_H = gpcc_pkg::GRID_H_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gpcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gpcc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] pixel_rgb565, [27:16] pixel_col, [39:28] pixel_row
	input  logic [gpcc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] found, [13:1] green_count, [20:14] center_col, [52:21] frame_number
	output logic [gpcc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	gpcc_pkg::cmd_t cmd;
	gpcc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	gpcc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	gpcc_dp #(
		.GRID_W (GRID_W),
		.GRID_H (GRID_H)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_axis_tdata),
		.s_tlast   (s_axis_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata)
	);

endmodule

@@ tb/tb_green_pixel_count_centroid.sv @@
// ---------------------------------------------------------------------------
// tb_green_pixel_count_centroid - stream testbench for the green sample counter
// Feeds RGB565 pixel frames through s_axis under several register settings,
// predicts each frame report (found, count, mean column, frame number) and
// checks every m_axis transfer against it, with random stalls on both sides.
// ---------------------------------------------------------------------------
module tb_green_pixel_count_centroid;

	localparam int GRID_W       = gpcc_pkg::GRID_W_DEF;
	localparam int GRID_H       = gpcc_pkg::GRID_H_DEF;
	localparam int COL_CAP      = (GRID_W - 1) < 127 ? GRID_W - 1 : 127;
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 680;
	localparam int PHASE_ITEMS  = 56;

	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_ENABLED       = 3'd0;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd1;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd2;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_MIN_GREEN     = 3'd3;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_GREENNESS_MIN = 3'd4;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_MIRROR_X      = 3'd5;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_SPARE_6       = 3'd6;
	localparam logic [gpcc_pkg::CFG_IDX_W-1:0] REG_SPARE_7       = 3'd7;

	localparam logic [15:0] RGB_GREEN = 16'h07E0;
	localparam logic [15:0] RGB_WHITE = 16'hFFFF;
	localparam logic [15:0] RGB_BLACK = 16'h0000;
	localparam logic [15:0] RGB_RED   = 16'hF800;
	localparam logic [15:0] RGB_BLUE  = 16'h001F;
	localparam logic [15:0] RGB_DIM   = 16'h0020;

	typedef struct packed {
		logic        last;
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] rgb;
	} pixel_t;

	typedef struct packed {
		logic [31:0] frame;
		logic [6:0]  center;
		logic [12:0] count;
		logic        found;
	} report_t;

	typedef struct packed {
		logic [gpcc_pkg::CFG_IDX_W-1:0]  index;
		logic [gpcc_pkg::CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [gpcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gpcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [gpcc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [gpcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	green_pixel_count_centroid dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// register copy and running frame totals of the predictor
	bit cfg_enabled = 1'b0;
	int cfg_width = 320;
	int cfg_height = 240;
	int cfg_min_green = 75;
	int cfg_greenness = 30;
	bit cfg_mirror = 1'b1;
	int green_total = 0;
	int col_total = 0;
	logic [31:0] frame_seq = '0;

	pixel_t pixel_feed[$];
	report_t pending_reports[$];
	reg_write_t reg_writes[$];
	int pixels_queued = 0;
	int pixels_accepted = 0;
	int send_idle_pct = 23;
	int recv_idle_pct = 60;
	int stall_cycles = 0;
	bit failed = 1'b0;

	task automatic tally_pixel(input pixel_t px);
		int r8, g8, b8, greenness, rows_hit, cols_hit, col_sum, g, mean;
		report_t rep;
		if (cfg_enabled && cfg_width != 0 && cfg_height != 0) begin
			r8 = int'(px.rgb[15:11]) * 255 / 31;
			g8 = int'(px.rgb[10:5]) * 255 / 63;
			b8 = int'(px.rgb[4:0]) * 255 / 31;
			greenness = g8 - (r8 + b8) / 2;
			if (g8 > cfg_min_green && greenness > cfg_greenness) begin
				rows_hit = 0;
				cols_hit = 0;
				col_sum = 0;
				for (g = 0; g < GRID_H; g++)
					if (g * cfg_height / GRID_H == int'(px.row))
						rows_hit++;
				for (g = 0; g < GRID_W; g++)
					if (g * cfg_width / GRID_W == int'(px.col)) begin
						cols_hit++;
						col_sum += cfg_mirror ? GRID_W - 1 - g : g;
					end
				green_total += rows_hit * cols_hit;
				if (green_total > int'(gpcc_pkg::COUNT_MAX))
					green_total = int'(gpcc_pkg::COUNT_MAX);
				col_total += rows_hit * col_sum;
				if (col_total > int'(gpcc_pkg::SUM_MAX))
					col_total = int'(gpcc_pkg::SUM_MAX);
			end
			if (px.last) begin
				mean = 0;
				if (green_total > 0) begin
					mean = col_total / green_total;
					if (mean > COL_CAP)
						mean = COL_CAP;
				end
				frame_seq = frame_seq + 32'd1;
				rep.found = green_total > 0;
				rep.count = 13'(green_total);
				rep.center = 7'(mean);
				rep.frame = frame_seq;
				pending_reports.push_back(rep);
				green_total = 0;
				col_total = 0;
			end
		end
	endtask

	task automatic latch_register(input reg_write_t w);
		case (w.index)
			REG_ENABLED: begin
				cfg_enabled = w.data[0];
				if (!w.data[0]) begin
					green_total = 0;
					col_total = 0;
				end
			end
			REG_FRAME_WIDTH: cfg_width = int'(w.data);
			REG_FRAME_HEIGHT: cfg_height = int'(w.data);
			REG_MIN_GREEN: cfg_min_green = int'(w.data[7:0]);
			REG_GREENNESS_MIN: cfg_greenness = int'(w.data[7:0]);
			REG_MIRROR_X: cfg_mirror = w.data[0];
			default: ;
		endcase
	endtask

	task automatic queue_reg(input logic [gpcc_pkg::CFG_IDX_W-1:0] idx, input int val);
		reg_write_t w;
		w.index = idx;
		w.data = 12'(val);
		reg_writes.push_back(w);
	endtask

	// call at a rising edge; transfers every queued write, then drops valid
	task automatic apply_reg_writes();
		reg_write_t w;
		while (reg_writes.size() > 0) begin
			w = reg_writes.pop_front();
			cfg_index <= w.index;
			cfg_data <= w.data;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			latch_register(w);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input pixel_t px);
		pixel_feed.push_back(px);
		pixels_queued++;
	endtask

	function automatic pixel_t grid_px(input int gx, input int gy, input logic [15:0] rgb,
			input bit last);
		pixel_t px;
		px.col = 12'(gx * cfg_width / GRID_W);
		px.row = 12'(gy * cfg_height / GRID_H);
		px.rgb = rgb;
		px.last = last;
		return px;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		if ($urandom_range(9) < 7) begin
			px = grid_px($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1), RGB_BLACK, 1'b0);
		end else begin
			px.col = 12'($urandom_range(4095));
			px.row = 12'($urandom_range(4095));
		end
		if ($urandom_range(9) < 6)
			px.rgb = {5'($urandom_range(12)), 6'($urandom_range(63, 30)), 5'($urandom_range(12))};
		else
			px.rgb = 16'($urandom_range(65535));
		px.last = 1'b0;
		return px;
	endfunction

	task automatic queue_random_frame();
		int len, k;
		pixel_t px;
		len = $urandom_range(10, 1);
		for (k = 1; k <= len; k++) begin
			// repeat the previous pixel now and then
			if (k == 1 || $urandom_range(9) != 0)
				px = random_pixel();
			px.last = (k == len);
			push_pixel(px);
		end
	endtask

	function automatic int pick_extent(input int grid);
		case ($urandom_range(9))
			0: return grid;
			1: return 4095;
			2: return $urandom_range(grid - 1, 1);
			default: return $urandom_range(640, grid);
		endcase
	endfunction

	function automatic int pick_level(input int typical);
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			default: return $urandom_range(typical);
		endcase
	endfunction

	// hold until every pixel is taken and every report is back, then drain
	task automatic settle();
		while (pixels_accepted != pixels_queued || pending_reports.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		pixel_t next_px;
		if (s_axis_tvalid && s_axis_tready) begin
			tally_pixel({s_axis_tlast, s_axis_tdata});
			pixels_accepted++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pixel_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_px = pixel_feed.pop_front();
				s_axis_tdata <= {next_px.row, next_px.col, next_px.rgb};
				s_axis_tlast <= next_px.last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		report_t want;
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual %h", $time, m_axis_tdata);
				failed = 1'b1;
			end else begin
				want = pending_reports.pop_front();
				check_field("found", 32'(want.found), 32'(m_axis_tdata[0]));
				check_field("green_count", 32'(want.count), 32'(m_axis_tdata[13:1]));
				check_field("center_col", 32'(want.center), 32'(m_axis_tdata[20:14]));
				check_field("frame_number", want.frame, m_axis_tdata[52:21]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("green_pixel_count_centroid test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int phase, first, random_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: pixels are dropped
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b0));
		push_pixel(grid_px(4, 4, RGB_GREEN, 1'b1));
		settle();

		queue_reg(REG_ENABLED, 1);
		apply_reg_writes();
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b0));
		push_pixel(grid_px(GRID_W - 1, GRID_H - 1, RGB_GREEN, 1'b0));
		push_pixel('{last: 1'b0, row: 12'd0, col: 12'd1, rgb: RGB_GREEN});
		push_pixel('{last: 1'b0, row: 12'd4095, col: 12'd4095, rgb: RGB_GREEN});
		push_pixel(grid_px(20, 20, RGB_WHITE, 1'b0));
		push_pixel(grid_px(21, 20, RGB_RED, 1'b0));
		push_pixel(grid_px(22, 20, RGB_BLUE, 1'b0));
		push_pixel(grid_px(40, 30, RGB_GREEN, 1'b0));
		push_pixel(grid_px(40, 30, RGB_GREEN, 1'b0));
		push_pixel(grid_px(10, 10, RGB_BLACK, 1'b1));
		push_pixel(grid_px(10, 10, RGB_BLACK, 1'b1));
		settle();

		queue_reg(REG_MIRROR_X, 0);
		queue_reg(REG_MIN_GREEN, 0);
		queue_reg(REG_GREENNESS_MIN, 0);
		apply_reg_writes();
		push_pixel(grid_px(5, 5, RGB_DIM, 1'b0));
		push_pixel(grid_px(7, 7, RGB_BLACK, 1'b0));
		push_pixel(grid_px(GRID_W - 1, 0, RGB_WHITE, 1'b1));
		settle();

		// interrupted frame is discarded by disabling
		push_pixel(grid_px(3, 3, RGB_GREEN, 1'b0));
		settle();
		queue_reg(REG_ENABLED, 0);
		queue_reg(REG_ENABLED, 1);
		apply_reg_writes();
		push_pixel(grid_px(2, 2, RGB_GREEN, 1'b1));
		settle();

		// one-pixel frame: every grid point lands on it, totals saturate
		queue_reg(REG_FRAME_WIDTH, 1);
		queue_reg(REG_FRAME_HEIGHT, 1);
		queue_reg(REG_MIN_GREEN, 75);
		queue_reg(REG_GREENNESS_MIN, 30);
		queue_reg(REG_MIRROR_X, 1);
		apply_reg_writes();
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b0));
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b0));
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b1));
		settle();

		queue_reg(REG_FRAME_WIDTH, 0);
		apply_reg_writes();
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b0));
		push_pixel(grid_px(0, 0, RGB_GREEN, 1'b1));
		settle();
		queue_reg(REG_FRAME_WIDTH, 4095);
		queue_reg(REG_FRAME_HEIGHT, 0);
		apply_reg_writes();
		push_pixel(grid_px(1, 1, RGB_GREEN, 1'b1));
		settle();

		queue_reg(REG_FRAME_HEIGHT, 4095);
		queue_reg(REG_MIN_GREEN, 'hFFF);
		queue_reg(REG_GREENNESS_MIN, 'hFFF);
		queue_reg(REG_SPARE_6, 'hFFF);
		queue_reg(REG_SPARE_7, 'hA5A);
		apply_reg_writes();
		push_pixel(grid_px(GRID_W - 1, GRID_H - 1, RGB_GREEN, 1'b1));
		settle();

		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase < 4) begin
				send_idle_pct = 23;
				recv_idle_pct = 60;
			end else if (phase < 8) begin
				send_idle_pct = 60;
				recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_reg(REG_ENABLED, int'({11'($urandom_range(2047)), $urandom_range(9) != 0}));
			queue_reg(REG_FRAME_WIDTH, pick_extent(GRID_W));
			queue_reg(REG_FRAME_HEIGHT, pick_extent(GRID_H));
			queue_reg(REG_MIN_GREEN, int'({4'($urandom_range(15)), 8'(pick_level(150))}));
			queue_reg(REG_GREENNESS_MIN, int'({4'($urandom_range(15)), 8'(pick_level(100))}));
			queue_reg(REG_MIRROR_X, int'({11'($urandom_range(2047)), 1'($urandom_range(1))}));
			apply_reg_writes();
			first = pixels_queued;
			while (pixels_queued - first < PHASE_ITEMS)
				queue_random_frame();
			random_items += pixels_queued - first;
			settle();
			phase++;
		end

		if (!failed && pending_reports.size() == 0)
			$display("green_pixel_count_centroid test passed");
		else
			$display("green_pixel_count_centroid test failed");
		$finish;
	end

endmodule
